// File: rtl/core/gpm_pkg.sv
package gpm_pkg;

  // pattern rom geometry
  localparam int RomLen  = 16;
  localparam int RomSize = 32;
  localparam int PosW    = 5;

  // number tracking modes
  typedef enum logic [1:0] {
    NumNone  = 2'd0,
    NumOct   = 2'd1,
    NumXSeen = 2'd2,
    NumHex   = 2'd3
  } num_mode_e;

  typedef logic [RomLen*8-1:0] pat_str_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic            alive;
    logic [1:0]      phase;
    num_mode_e       mode;
    logic [7:0]      cands;
  } cell_st_t;

  // pattern rom, right-aligned literals
  function automatic pat_str_t pat_str(input int idx);
    pat_str_t s;
    unique case (idx)
      0:  s = "pop %R";
      1:  s = "popa";
      2:  s = "push %R";
      3:  s = "pusha";
      4:  s = "add %R,[%X]";
      5:  s = "add %R,[%R+%X]";
      6:  s = "add %R,[%R-%X]";
      7:  s = "add %R,[%R]";
      8:  s = "add %R,%X";
      9:  s = "add %R,%R";
      10: s = "add [%R],%R";
      11: s = "add [%R+%X],%R";
      12: s = "add [%R-%X],%R";
      13: s = "int %X";
      14: s = "call %R";
      15: s = "call [%R]";
      16: s = "jmp [%R]";
      17: s = "jmp %R";
      18: s = "mov %R,%R";
      19: s = "mov [%R+%X],%R";
      20: s = "mov [%R-%X],%R";
      21: s = "mov [%R],%R";
      22: s = "mov %R,[%R]";
      23: s = "mov %R,[%R+%X]";
      24: s = "mov %R,[%R-%X]";
      25: s = "add [%R],%b";
      26: s = "add [%R+%X],%b";
      27: s = "add [%R-%X],%b";
      28: s = "xchg %R,%R";
      29: s = "leave";
      30: s = "ret";
      31: s = "retn %X";
      default: s = '0;
    endcase
    return s;
  endfunction

  // count of nonzero bytes in a right-aligned literal
  function automatic int pat_len(input pat_str_t s);
    int n;
    n = 0;
    for (int b = 0; b < RomLen; b++) begin
      if (s[b*8 +: 8] != 8'h00) n = b + 1;
    end
    return n;
  endfunction

  // register name tables
  function automatic logic [7:0] reg32_char(input int k, input logic [1:0] ph);
    logic [23:0] nm;
    unique case (k)
      0: nm = "eax";
      1: nm = "ebx";
      2: nm = "ecx";
      3: nm = "edx";
      4: nm = "esp";
      5: nm = "ebp";
      6: nm = "esi";
      default: nm = "edi";
    endcase
    unique case (ph)
      2'd0:    return nm[23:16];
      2'd1:    return nm[15:8];
      default: return nm[7:0];
    endcase
  endfunction

  function automatic logic [7:0] reg8_char(input int k, input logic ph);
    logic [15:0] nm;
    unique case (k)
      0: nm = "al";
      1: nm = "bl";
      2: nm = "cl";
      default: nm = "dl";
    endcase
    return ph ? nm[7:0] : nm[15:8];
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic cell_st_t cell_clear();
    cell_st_t s;
    s.pos   = '0;
    s.alive = 1'b1;
    s.phase = 2'd0;
    s.mode  = NumNone;
    s.cands = 8'h00;
    return s;
  endfunction

endpackage

// File: rtl/core/gpm_cell.sv
module gpm_cell import gpm_pkg::*; #(
  parameter int Idx = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_code_i,
  input  logic       end_i,
  input  logic       any_i,
  output logic       any_o
);

  localparam pat_str_t Pat = pat_str(Idx);
  localparam int       Len = pat_len(Pat);

  cell_st_t st_q, st_d;

  // pattern character at a position, zero past the end
  function automatic logic [7:0] pat_at(input logic [PosW:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    for (int p = 0; p < Len; p++) begin
      if (pos == (PosW+1)'(p)) ch = Pat[(Len-1-p)*8 +: 8];
    end
    return ch;
  endfunction

  // one character outside a number
  function automatic cell_st_t plain(input cell_st_t si, input logic [7:0] c);
    cell_st_t   s;
    logic [7:0] p;
    logic [7:0] p2;
    logic [7:0] m;
    logic       is_r;
    s    = si;
    p    = pat_at({1'b0, s.pos});
    p2   = pat_at({1'b0, s.pos} + 1'b1);
    is_r = (p2 == "R");
    m    = 8'h00;
    if (p == 8'h00) begin
      s.alive = 1'b0;
    end else if (p != "%") begin
      if (p == c) s.pos = s.pos + 1'b1;
      else s.alive = 1'b0;
    end else if (p2 == "X") begin
      if (c == "0") begin
        s.mode  = NumOct;
        s.phase = 2'd0;
      end else begin
        s.alive = 1'b0;
      end
    end else if (is_r || p2 == "b") begin
      if (s.phase == 2'd0) m = is_r ? 8'hff : 8'h0f;
      else m = s.cands;
      for (int k = 0; k < 8; k++) begin
        if (is_r) begin
          if (reg32_char(k, s.phase) != c) m[k] = 1'b0;
        end else if (k < 4) begin
          if (reg8_char(k, s.phase[0]) != c) m[k] = 1'b0;
        end
      end
      s.cands = m;
      if (m == 8'h00) begin
        s.alive = 1'b0;
      end else if (s.phase == (is_r ? 2'd2 : 2'd1)) begin
        s.phase = 2'd0;
        s.pos   = s.pos + PosW'(2);
      end else begin
        s.phase = s.phase + 1'b1;
      end
    end else begin
      s.alive = 1'b0;
    end
    return s;
  endfunction

  // end of a number, with a pending x fed as a plain character
  function automatic cell_st_t close_num(input cell_st_t si);
    cell_st_t   s;
    logic [7:0] pend;
    s       = si;
    pend    = (si.phase != 2'd0) ? "X" : "x";
    s.mode  = NumNone;
    s.phase = 2'd0;
    s.pos   = s.pos + PosW'(2);
    if (si.mode == NumXSeen) s = plain(s, pend);
    return s;
  endfunction

  function automatic cell_st_t feed(input cell_st_t si, input logic [7:0] c);
    cell_st_t s;
    logic     took;
    s    = si;
    took = 1'b0;
    if (si.mode == NumOct) begin
      if (c >= "0" && c <= "7") begin
        s.phase = 2'd1;
        took    = 1'b1;
      end else if (si.phase == 2'd0 && (c == "x" || c == "X")) begin
        s.mode  = NumXSeen;
        s.phase = (c == "X") ? 2'd1 : 2'd0;
        took    = 1'b1;
      end
    end else if (si.mode != NumNone) begin
      if (is_hex(c)) begin
        s.mode  = NumHex;
        s.phase = 2'd0;
        took    = 1'b1;
      end
    end
    if (!took) begin
      if (si.mode != NumNone) s = close_num(s);
      if (s.alive) s = plain(s, c);
    end
    return s;
  endfunction

  cell_st_t fed;
  cell_st_t fin;
  logic     hit;

  // per-character update and end-of-string check
  always_comb begin
    fed = st_q;
    if (st_q.alive && char_code_i != 8'h00) fed = feed(st_q, char_code_i);
    fin = fed;
    if (fed.alive && fed.mode != NumNone) fin = close_num(fed);
    hit = fin.alive && fin.mode == NumNone && fin.phase == 2'd0
          && pat_at({1'b0, fin.pos}) == 8'h00;
    st_d = st_q;
    if (step_i) st_d = end_i ? cell_clear() : fed;
  end

  // match bit rides down the chain
  assign any_o = any_i | hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cell_clear();
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/core/gadget_pattern_matcher_unit.sv
// gadget pattern matcher
// input channel: one word per character, char_code_i with last_char_i.
// a string ends on a word with last_char_i set or on a zero byte; the zero
// byte itself is not part of the string.
// output channel: one word per string, matched_o is 1 when the whole string
// matched at least one pattern of the rom.
// every pattern has its own cell; all cells step on the same character, so
// one character is taken every cycle unless in_stall_o is high. the result
// is registered in the cycle after the ending word is accepted.
// in_stall_o is raised only while a result is held and out_stall_i is high;
// a waiting result does not block characters that end no string.
// at reset all cells are cleared and no result is pending.
module gadget_pattern_matcher_unit import gpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o
);

  logic             accept;
  logic             str_end;
  logic [RomSize:0] chain;
  logic             out_valid_q, out_valid_d;
  logic             matched_q, matched_d;
  logic             out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign str_end    = last_char_i || (char_code_i == 8'h00);
  assign in_stall_o = !out_free && str_end;
  assign accept     = in_valid_i && !in_stall_o;

  // row of pattern cells
  assign chain[0] = 1'b0;
  for (genvar g = 0; g < RomSize; g++) begin : g_cell
    gpm_cell #(.Idx(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (accept),
      .char_code_i (char_code_i),
      .end_i       (str_end),
      .any_i       (chain[g]),
      .any_o       (chain[g+1])
    );
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    if (out_free) begin
      out_valid_d = accept && str_end;
      matched_d   = chain[RomSize];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      matched_q   <= matched_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule
